FILE: src/mlp_segment_digit_classifier_defines.svh
// Assertion macros shared by the checker of the segment digit classifier.
`ifndef MLP_SEGMENT_DIGIT_CLASSIFIER_DEFINES_SVH
`define MLP_SEGMENT_DIGIT_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SDC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdc checker: implication failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define SDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdc checker: next-cycle implication failed");

`endif

FILE: src/sdc_pkg.sv
// Types, weight ROMs, sigmoid table and helper functions of the segment digit classifier.
`default_nettype none
package sdc_pkg;

    localparam int INPUT_COUNT     = 7;
    localparam int HIDDEN_COUNT    = 15;
    localparam int OUTPUT_COUNT    = 4;
    localparam int SIGMOID_ENTRIES = 256;

    localparam int SEG_W      = 8;
    localparam int HID_W_W    = 16;
    localparam int HID_SUM_W  = 19;
    localparam int SIG_SHIFT  = 11;
    localparam int SIG_IDX_W  = $clog2(SIGMOID_ENTRIES);
    localparam int ACT_W      = 16;
    localparam int OUT_W_W    = 16;
    localparam int PROD_W     = ACT_W + 1 + OUT_W_W;
    localparam int ACC_W      = 40;
    localparam int DIGIT_W    = 4;

    localparam logic [SEG_W-1:0]   ERROR_GLYPH = 8'hE7;
    localparam logic [DIGIT_W-1:0] DIGIT_LIMIT = 4'd9;

    typedef logic [INPUT_COUNT-1:0]        mask_t;
    typedef logic [ACT_W-1:0]              act_t;
    typedef logic signed [ACC_W-1:0]       acc_t;
    typedef acc_t                          acc_vec_t [OUTPUT_COUNT];
    typedef logic [HID_W_W-1:0]            hid_row_t [INPUT_COUNT];
    typedef logic signed [OUT_W_W-1:0]     out_col_t [OUTPUT_COUNT];
    typedef logic [ACT_W-1:0]              sig_table_t [SIGMOID_ENTRIES];

    typedef struct packed {
        logic  valid;
        mask_t mask;
        act_t  act;
    } stage_t;

    localparam int HID_W [HIDDEN_COUNT][INPUT_COUNT] = '{
        '{10710, 34295, 31122, 40338, 16614, 31924, 64217},
        '{41069, 28255, 57204, 34114, 35712, 32724, 38699},
        '{10740, 43870, 55847, 20367, 43950, 49046, 28768},
        '{31218, 54067, 5572, 57106, 12348, 30053, 64208},
        '{60891, 8676, 51322, 1981, 16916, 56582, 84},
        '{13798, 49161, 30884, 9116, 11753, 17440, 8074},
        '{36629, 57078, 37748, 52879, 43289, 53154, 46741},
        '{55340, 48265, 13066, 11615, 28234, 18284, 18073},
        '{14516, 37602, 27003, 30274, 6419, 53250, 32240},
        '{3923, 16631, 63319, 52250, 50994, 19027, 2112},
        '{49379, 64721, 32859, 53368, 30572, 16600, 54464},
        '{57622, 58746, 65473, 15779, 34037, 11815, 63331},
        '{61166, 54966, 29648, 61674, 13897, 43310, 38527},
        '{60309, 15772, 44246, 24680, 31358, 10178, 5370},
        '{53830, 21730, 51822, 43858, 38312, 20517, 52019}
    };

    localparam int OUT_W [OUTPUT_COUNT][HIDDEN_COUNT] = '{
        '{2073, 2233, 11165, 8331, 3716, -265, -5337, -4235,
          -10618, -1886, 12137, -12098, -15667, 7353, 3390},
        '{-3187, 6049, -1007, -13209, -3130, -6300, 3532, -16774,
          11327, -8155, -2031, 16155, 8348, 2882, 3177},
        '{-14668, 3930, 4150, -19363, -9783, 7691, 11623, -9182,
          658, -12116, 6936, 20637, 7736, -4176, 2844},
        '{17043, -4484, -1843, 22323, 4622, 4283, -19594, 11420,
          -3613, 210, -7880, -11614, -13390, 11184, -4497}
    };

    localparam logic [SEG_W-1:0] DIGIT_GLYPHS [10] = '{
        8'h7E, 8'h18, 8'hB6, 8'hBC, 8'hD8, 8'hEC, 8'hEE, 8'h38, 8'hFE, 8'hFC
    };

    // Fixed-point helpers below run only at elaboration to build the table.
    localparam int FRAC = 60;

    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (FRAC - 1));
        return p[FRAC+63:FRAC];
    endfunction

    function automatic logic [63:0] udiv(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] exp_neg_64th();
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] d;
        term = 64'd1 << FRAC;
        sum  = 64'd1 << FRAC;
        for (int n = 1; n < 40; n++) begin
            if (term != 64'd0) begin
                d = 64'(64 * n);
                term = udiv(term + (d >> 1), d);
                if (n % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic sig_table_t build_sig_table();
        sig_table_t  t;
        logic [63:0] e64;
        logic [63:0] e32;
        logic [63:0] cur;
        logic [63:0] den;
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] v;
        e64 = exp_neg_64th();
        e32 = qmul(e64, e64);
        cur = e64;
        for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
            den = (64'd1 << FRAC) + cur;
            r = 64'd1 << FRAC;
            q = '0;
            if (r >= den) begin
                q = 64'd1;
                r = r - den;
            end
            for (int s = 0; s < 17; s++) begin
                r = r << 1;
                q = q << 1;
                if (r >= den) begin
                    r = r - den;
                    q = q | 64'd1;
                end
            end
            v = (q + 64'd1) >> 1;
            t[i] = (v > 64'd65535) ? 16'hFFFF : v[ACT_W-1:0];
            cur = qmul(cur, e32);
        end
        return t;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

    // Hidden neuron: add the weights of the set inputs, then look up the sigmoid.
    function automatic act_t hidden_act(mask_t m, hid_row_t w);
        logic [HID_SUM_W-1:0] s;
        logic [HID_SUM_W-1:0] idx;
        s = '0;
        for (int b = 0; b < INPUT_COUNT; b++) begin
            if (m[b])
                s = s + HID_SUM_W'(w[b]);
        end
        idx = s >> SIG_SHIFT;
        if (idx > HID_SUM_W'(SIGMOID_ENTRIES - 1))
            idx = HID_SUM_W'(SIGMOID_ENTRIES - 1);
        return SIG_TABLE[idx[SIG_IDX_W-1:0]];
    endfunction

endpackage
`default_nettype wire

FILE: src/mlp_segment_digit_classifier.sv
// Top level of the segment digit classifier: input stage, chain of neuron cells, output stage.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------
//  in      | input     | in_valid / in_ready   | segment_mask[7:0]
//  out     | output    | out_valid / out_ready | display_byte[7:0], predicted_digit[3:0],
//          |           |                       | out_of_range
//
// A new word is taken every cycle unless the output stalls; the accepting edge loads the
// input stage, then the word moves through each hidden-neuron cell (15) and on into the
// output register.
// The chain advances as one pipeline; a stalled output word freezes every stage.
// Reset clears only the stage valid bits; no clearing pass is needed.
`default_nettype none
module mlp_segment_digit_classifier
    import sdc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [SEG_W-1:0]   segment_mask,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [SEG_W-1:0]        display_byte,
    output logic [DIGIT_W-1:0]      predicted_digit,
    output logic                    out_of_range
);

    logic     advance;
    stage_t   stage [HIDDEN_COUNT+1];
    acc_vec_t acc   [HIDDEN_COUNT+1];
    hid_row_t w_first;

    assign in_ready = advance;

    always_comb
    begin
        for (int b = 0; b < INPUT_COUNT; b++)
            w_first[b] = HID_W_W'(HID_W[0][b]);
    end

    for (genvar j = 0; j < OUTPUT_COUNT; j++)
    begin : g_acc0
        assign acc[0][j] = '0;
    end

    sdc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .in_valid     (in_valid),
        .segment_mask (segment_mask),
        .w_first      (w_first),
        .out_stage    (stage[0])
    );

    for (genvar h = 0; h < HIDDEN_COUNT; h++)
    begin : g_cell
        hid_row_t w_next;
        out_col_t w_out;

        // Each cell also computes the activation of the neuron after it.
        if (h + 1 < HIDDEN_COUNT)
        begin : g_next
            for (genvar b = 0; b < INPUT_COUNT; b++)
            begin : g_w
                assign w_next[b] = HID_W_W'(HID_W[h+1][b]);
            end
        end
        else
        begin : g_last
            for (genvar b = 0; b < INPUT_COUNT; b++)
            begin : g_w
                assign w_next[b] = '0;
            end
        end

        for (genvar j = 0; j < OUTPUT_COUNT; j++)
        begin : g_o
            assign w_out[j] = OUT_W_W'(OUT_W[j][h]);
        end

        sdc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .w_next    (w_next),
            .w_out     (w_out),
            .in_stage  (stage[h]),
            .in_acc    (acc[h]),
            .out_stage (stage[h+1]),
            .out_acc   (acc[h+1])
        );
    end

    sdc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (stage[HIDDEN_COUNT].valid),
        .in_acc          (acc[HIDDEN_COUNT]),
        .out_ready       (out_ready),
        .advance         (advance),
        .out_valid       (out_valid),
        .display_byte    (display_byte),
        .predicted_digit (predicted_digit),
        .out_of_range    (out_of_range)
    );

endmodule
`default_nettype wire

FILE: src/sdc_front.sv
// Input stage: unpacks the segment byte and computes the first hidden activation.
`default_nettype none
module sdc_front
    import sdc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic             in_valid,
    input  wire logic [SEG_W-1:0] segment_mask,
    input  wire hid_row_t         w_first,
    output stage_t                out_stage
);

    logic  valid_reg;
    mask_t mask_reg;
    mask_t mask_next;
    act_t  act_reg;

    // Input k of the network is bit 7-k of the segment byte.
    always_comb
    begin
        for (int k = 0; k < INPUT_COUNT; k++)
            mask_next[k] = segment_mask[SEG_W-1-k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mask_reg <= mask_next;
            act_reg  <= hidden_act(mask_next, w_first);
        end
    end

    assign out_stage = '{valid: valid_reg, mask: mask_reg, act: act_reg};

endmodule
`default_nettype wire

FILE: src/sdc_cell.sv
// One hidden-neuron cell: folds its activation into the output sums and
// prepares the activation of the next neuron.
`default_nettype none
module sdc_cell
    import sdc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     advance,
    input  wire hid_row_t w_next,
    input  wire out_col_t w_out,
    input  wire stage_t   in_stage,
    input  wire acc_vec_t in_acc,
    output stage_t        out_stage,
    output acc_vec_t      out_acc
);

    logic                     valid_reg;
    mask_t                    mask_reg;
    act_t                     act_reg;
    acc_vec_t                 acc_reg;
    acc_vec_t                 acc_next;
    logic signed [PROD_W-1:0] prod [OUTPUT_COUNT];

    always_comb
    begin
        for (int j = 0; j < OUTPUT_COUNT; j++)
        begin
            prod[j]     = $signed({1'b0, in_stage.act}) * w_out[j];
            acc_next[j] = in_acc[j] + ACC_W'(prod[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_stage.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mask_reg <= in_stage.mask;
            act_reg  <= hidden_act(in_stage.mask, w_next);
            for (int j = 0; j < OUTPUT_COUNT; j++)
                acc_reg[j] <= acc_next[j];
        end
    end

    assign out_stage = '{valid: valid_reg, mask: mask_reg, act: act_reg};
    assign out_acc   = acc_reg;

endmodule
`default_nettype wire

FILE: src/sdc_back.sv
// Output stage: thresholds the output sums, maps the digit to a glyph and
// holds the result word until it is taken.
`default_nettype none
module sdc_back
    import sdc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire acc_vec_t            in_acc,
    input  wire logic                out_ready,
    output logic                     advance,
    output logic                     out_valid,
    output logic [SEG_W-1:0]         display_byte,
    output logic [DIGIT_W-1:0]       predicted_digit,
    output logic                     out_of_range
);

    logic [OUTPUT_COUNT-1:0] code;
    logic [DIGIT_W-1:0]      digit_next;
    logic                    oor_next;
    logic [SEG_W-1:0]        display_next;
    logic                    valid_reg;
    logic [SEG_W-1:0]        display_reg;
    logic [DIGIT_W-1:0]      digit_reg;
    logic                    oor_reg;

    always_comb
    begin
        for (int j = 0; j < OUTPUT_COUNT; j++)
            code[j] = (in_acc[j] > 0);
        digit_next = DIGIT_W'(code);
        oor_next   = (digit_next > DIGIT_LIMIT);
        if (oor_next)
            display_next = ERROR_GLYPH;
        else
            display_next = DIGIT_GLYPHS[digit_next] + SEG_W'(1);
    end

    // The whole pipeline moves whenever the output register is free or being read.
    assign advance = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            display_reg <= display_next;
            digit_reg   <= digit_next;
            oor_reg     <= oor_next;
        end
    end

    assign out_valid       = valid_reg;
    assign display_byte    = display_reg;
    assign predicted_digit = digit_reg;
    assign out_of_range    = oor_reg;

endmodule
`default_nettype wire

FILE: src/sdc_checker.sv
// Port-level assertions for the segment digit classifier, bound to its top level.
`default_nettype none
`include "mlp_segment_digit_classifier_defines.svh"
module sdc_checker
    import sdc_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic [SEG_W-1:0]   segment_mask,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [SEG_W-1:0]   display_byte,
    input wire logic [DIGIT_W-1:0] predicted_digit,
    input wire logic               out_of_range
);

    // A stalled result word stays in place.
    `SDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(display_byte))

    // The range flag agrees with the digit it describes.
    `SDC_ASSERT_IMPLY(a_range_flag, out_valid, out_of_range == (predicted_digit > DIGIT_LIMIT))

    // An out-of-range digit shows the error glyph.
    `SDC_ASSERT_IMPLY(a_error_glyph, out_valid && out_of_range, display_byte == ERROR_GLYPH)

    // A valid digit always shows its dot.
    `SDC_ASSERT_IMPLY(a_dot_set, out_valid && !out_of_range, display_byte[0])

    // With the output register empty the pipeline never refuses a word.
    `SDC_ASSERT_IMPLY(a_ready_free, !out_valid, in_ready)

endmodule

bind mlp_segment_digit_classifier sdc_checker u_sdc_checker (.*);
`default_nettype wire

FILE: tb/mlp_segment_digit_classifier_tb.sv
// Testbench for the segment digit classifier, checked against its own network predictor.
`default_nettype none
module mlp_segment_digit_classifier_tb;
    import sdc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 900;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [SEG_W-1:0]   display;
        logic [DIGIT_W-1:0] digit;
        logic               oor;
    } digit_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [SEG_W-1:0]   segment_mask;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [SEG_W-1:0]   display_byte;
    logic [DIGIT_W-1:0] predicted_digit;
    logic               out_of_range;

    logic [15:0]   sigmoid_lut [SIGMOID_ENTRIES];
    digit_result_t expected_digits [$];
    int            error_count = 0;
    int            cycle_count = 0;
    int            send_idle_pct;
    int            recv_stall_pct;

    mlp_segment_digit_classifier DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .segment_mask    (segment_mask),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .display_byte    (display_byte),
        .predicted_digit (predicted_digit),
        .out_of_range    (out_of_range)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Fixed-point product with 60 fraction bits, rounded.
    function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) + (128'd1 << 59);
        return p[123:60];
    endfunction

    // Sigmoid at the midpoint of each 1/32 step, scaled by 65536 and rounded.
    task automatic fill_sigmoid_lut();
        logic [63:0]  one_q;
        logic [63:0]  term;
        logic [63:0]  e_step;
        logic [63:0]  e_double;
        logic [63:0]  cur;
        logic [63:0]  dv;
        logic [127:0] quot;
        logic [127:0] half_up;
        one_q  = 64'd1 << 60;
        term   = one_q;
        e_step = one_q;
        for (int n = 1; n < 40 && term != 0; n++)
        begin
            dv = 64'(64 * n);
            term = (term + dv / 2) / dv;
            e_step = (n % 2 == 1) ? e_step - term : e_step + term;
        end
        e_double = fx_mul(e_step, e_step);
        cur = e_step;
        for (int i = 0; i < SIGMOID_ENTRIES; i++)
        begin
            quot = (128'd1 << 77) / {64'd0, one_q + cur};
            half_up = (quot + 1) >> 1;
            sigmoid_lut[i] = (half_up > 128'd65535) ? 16'hFFFF : half_up[15:0];
            cur = fx_mul(cur, e_double);
        end
    endtask

    function automatic digit_result_t classify_segments(logic [SEG_W-1:0] seg);
        longint        acc [OUTPUT_COUNT];
        int unsigned   hsum;
        int unsigned   idx;
        logic [3:0]    code;
        digit_result_t res;
        for (int j = 0; j < OUTPUT_COUNT; j++)
            acc[j] = 0;
        for (int h = 0; h < HIDDEN_COUNT; h++)
        begin
            hsum = 0;
            for (int k = 0; k < INPUT_COUNT; k++)
                if (seg[7 - k])
                    hsum += HID_W[h][k];
            idx = hsum >> 11;
            if (idx > SIGMOID_ENTRIES - 1)
                idx = SIGMOID_ENTRIES - 1;
            for (int j = 0; j < OUTPUT_COUNT; j++)
                acc[j] += longint'(OUT_W[j][h]) * longint'(sigmoid_lut[idx]);
        end
        code = '0;
        for (int j = 0; j < OUTPUT_COUNT; j++)
            code[j] = (acc[j] > 0);
        res.digit = code;
        res.oor = (code > DIGIT_LIMIT);
        res.display = res.oor ? ERROR_GLYPH : DIGIT_GLYPHS[code] + 8'd1;
        return res;
    endfunction

    task automatic send_word(logic [SEG_W-1:0] seg);
        logic taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        segment_mask <= seg;
        expected_digits.push_back(classify_segments(seg));
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end while (!taken);
    endtask

    always @(posedge clk)
    begin
        if ($urandom_range(99) < recv_stall_pct)
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    // Signals are settled at the falling edge; a word seen here is taken at the next rise.
    always @(negedge clk)
    begin
        digit_result_t exp_word;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_digits.size() == 0)
            begin
                $display("%0t: unexpected word display=%h digit=%h oor=%b",
                         $time, display_byte, predicted_digit, out_of_range);
                error_count++;
            end
            else
            begin
                exp_word = expected_digits.pop_front();
                if (display_byte !== exp_word.display)
                begin
                    $display("%0t: display_byte expected %h actual %h",
                             $time, exp_word.display, display_byte);
                    error_count++;
                end
                if (predicted_digit !== exp_word.digit)
                begin
                    $display("%0t: predicted_digit expected %h actual %h",
                             $time, exp_word.digit, predicted_digit);
                    error_count++;
                end
                if (out_of_range !== exp_word.oor)
                begin
                    $display("%0t: out_of_range expected %b actual %b",
                             $time, exp_word.oor, out_of_range);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        // Extremes, the ignored dot bit, every single segment and every digit glyph.
        logic [SEG_W-1:0] directed_masks [24] = '{
            8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h40, 8'h20, 8'h10,
            8'h08, 8'h04, 8'h02, 8'h7E, 8'h18, 8'hB6, 8'hBC, 8'hD8,
            8'hEC, 8'hEE, 8'h38, 8'hFE, 8'hFC, 8'h7F, 8'hE7, 8'hAA
        };
        int phase_len;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        segment_mask   = '0;
        send_idle_pct  = 16;
        recv_stall_pct = 56;
        fill_sigmoid_lut();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_masks[i])
            send_word(directed_masks[i]);

        phase_len = RANDOM_ITEMS / 3;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == phase_len)
            begin
                // Let the pipeline drain completely once before changing the pace.
                in_valid <= 1'b0;
                while (expected_digits.size() != 0)
                    @(posedge clk);
                send_idle_pct  = 56;
                recv_stall_pct = 16;
            end
            else if (n == 2 * phase_len)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            send_word(8'($urandom_range(255)));
        end
        in_valid <= 1'b0;

        while (expected_digits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
